[design/srsi_pkg.sv]
// ----------------------------------------------------------------------------
// srsi_pkg
// shared types and constants for the sorted range seek iterator
// ----------------------------------------------------------------------------
`default_nettype none

package srsi_pkg;

  localparam int ID_W           = 31;
  localparam int COUNT_W        = 9;
  localparam int SLOT_W         = 8;
  localparam int MODE_W         = 2;
  localparam int MAX_RANGES_DEF = 256;

  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEEK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REWIND = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0] first;
    logic [ID_W-1:0] last;
  } range_t;

  typedef struct packed {
    logic            exhausted;
    logic [ID_W-1:0] next_doc;
  } result_t;

endpackage

`default_nettype wire

[design/sorted_range_seek_iterator.sv]
// ----------------------------------------------------------------------------
// sorted_range_seek_iterator
// range list seek iterator with forward-only cursor (rewind resets it) over a range table
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | contents
//  s_*      | in        | s_tvalid/s_tready  | request: load, seek or rewind
//  m_*      | out       | m_tvalid/m_tready  | one result per request
//  cfg_*    | in        | cfg_valid/cfg_ready| range_count register
//
//  states from accept to m_tvalid: load, rewind, end-marker seek: S_OUT, then output register
//  seek: S_READ and S_CMP per range tried, then S_OUT; if it runs out, S_READ goes to S_OUT
//  s_tready low until the result enters the output register; one request at a time
//  a held output register stalls the sequencer; a new request waits behind it
//  no table clearing pass after reset; rst clears cursor and range_count
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_range_seek_iterator #(
  parameter int MAX_RANGES = srsi_pkg::MAX_RANGES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [103:0] s_tdata,   // slot, begin_doc, end_doc, doc_id, zero fill
  input  wire logic [2:0]   s_tuser,   // mode, seek_end
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [31:0]       m_tdata,   // next_doc, zero fill
  output logic [0:0]        m_tuser,   // exhausted
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [srsi_pkg::COUNT_W-1:0] cfg_data
);

  localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW = $clog2(MAX_RANGES + 1);

  logic [srsi_pkg::COUNT_W-1:0] range_count;
  logic                         out_free;
  logic                         res_valid;
  srsi_pkg::result_t            res;
  srsi_pkg::result_t            out_res;
  logic                         mem_wr_en;
  logic [AW-1:0]                mem_wr_addr;
  srsi_pkg::range_t             mem_wr_data;
  logic                         mem_rd_en;
  logic [AW-1:0]                mem_rd_addr;
  srsi_pkg::range_t             mem_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      range_count <= cfg_data;
    end
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {1'b0, out_res.next_doc};
  assign m_tuser = out_res.exhausted;

  srsi_seek_ctrl #(
    .MAX_RANGES (MAX_RANGES),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_mode     (s_tuser[1:0]),
    .in_slot     (s_tdata[7:0]),
    .in_first    (s_tdata[38:8]),
    .in_last     (s_tdata[69:39]),
    .in_target   (s_tdata[100:70]),
    .in_seek_end (s_tuser[2]),
    .range_count (range_count),
    .out_free    (out_free),
    .res_valid   (res_valid),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  srsi_range_mem #(
    .DEPTH (MAX_RANGES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

`default_nettype wire

[design/srsi_range_mem.sv]
// ----------------------------------------------------------------------------
// srsi_range_mem
// range table: one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module srsi_range_mem #(
  parameter int DEPTH = srsi_pkg::MAX_RANGES_DEF,
  parameter int AW    = 8
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire srsi_pkg::range_t wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output srsi_pkg::range_t     rd_data
);

  srsi_pkg::range_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[design/srsi_seek_ctrl.sv]
// ----------------------------------------------------------------------------
// srsi_seek_ctrl
// request sequencer: cursor, one shared range compare step per table read
// ----------------------------------------------------------------------------
`default_nettype none

module srsi_seek_ctrl #(
  parameter int MAX_RANGES = srsi_pkg::MAX_RANGES_DEF,
  parameter int AW         = 8,
  parameter int CW         = 9
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [srsi_pkg::MODE_W-1:0]   in_mode,
  input  wire logic [srsi_pkg::SLOT_W-1:0]   in_slot,
  input  wire logic [srsi_pkg::ID_W-1:0]     in_first,
  input  wire logic [srsi_pkg::ID_W-1:0]     in_last,
  input  wire logic [srsi_pkg::ID_W-1:0]     in_target,
  input  wire logic                          in_seek_end,
  input  wire logic [srsi_pkg::COUNT_W-1:0]  range_count,
  input  wire logic                          out_free,
  output logic                               res_valid,
  output srsi_pkg::result_t                  res,
  output logic                               mem_wr_en,
  output logic [AW-1:0]                      mem_wr_addr,
  output srsi_pkg::range_t                   mem_wr_data,
  output logic                               mem_rd_en,
  output logic [AW-1:0]                      mem_rd_addr,
  input  wire srsi_pkg::range_t              mem_rd_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t                      state;
  logic [CW-1:0]               cursor;
  logic [srsi_pkg::ID_W-1:0]   target;
  logic                        accept;
  logic                        past_end;
  logic                        hit;
  logic [srsi_pkg::ID_W-1:0]   hit_doc;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // cursor at or past the usable count (count clipped to table depth)
  assign past_end = (32'(cursor) >= 32'(range_count)) || (32'(cursor) >= 32'(MAX_RANGES));

  assign mem_wr_en        = accept && (in_mode == srsi_pkg::MODE_LOAD)
                            && (32'(in_slot) < 32'(MAX_RANGES));
  assign mem_wr_addr      = AW'(in_slot);
  assign mem_wr_data      = {in_first, in_last};
  assign mem_rd_en        = (state == S_READ) && !past_end;
  assign mem_rd_addr      = AW'(cursor);

  // shared compare unit
  assign hit     = (target <= mem_rd_data.last);
  assign hit_doc = (target >= mem_rd_data.first) ? target : mem_rd_data.first;

  assign res_valid = (state == S_OUT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cursor <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            target        <= in_target;
            res.next_doc  <= '0;
            res.exhausted <= 1'b0;
            case (in_mode)
              srsi_pkg::MODE_REWIND: begin
                cursor <= '0;
                state  <= S_OUT;
              end
              srsi_pkg::MODE_SEEK: begin
                if (in_seek_end) begin
                  res.exhausted <= 1'b1;
                  state         <= S_OUT;
                end else begin
                  state <= S_READ;
                end
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_READ: begin
          if (past_end) begin
            res.exhausted <= 1'b1;
            state         <= S_OUT;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (hit) begin
            res.next_doc <= hit_doc;
            state        <= S_OUT;
          end else begin
            cursor <= cursor + 1'b1;
            state  <= S_READ;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) 32'(cursor) <= 32'(MAX_RANGES))
    else $error("cursor beyond table depth");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> ($past(state) == S_READ))
    else $error("compare step without table read");

  assert property (@(posedge clk) disable iff (rst)
    (cursor != $past(cursor)) |-> ((cursor == $past(cursor) + 1'b1) || (cursor == '0)))
    else $error("cursor moved other than forward by one or rewind");

  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.exhausted) |-> (res.next_doc == '0))
    else $error("exhausted result with nonzero doc");

  assert property (@(posedge clk) disable iff (rst)
    mem_rd_en |-> (32'(cursor) < 32'(MAX_RANGES)))
    else $error("table read out of range");

endmodule

`default_nettype wire
